### rtl/assert_macros.svh
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ctp_pkg.sv
package ctp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic       time_ok;
        logic [2:0] error_code;
    } t_out_word;

    typedef enum logic [4:0] {
        PH_HOUR1  = 5'b00001,
        PH_HOUR2  = 5'b00010,
        PH_AFTER2 = 5'b00100,
        PH_MINUTE = 5'b01000,
        PH_IGNORE = 5'b10000
    } t_phase;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HOUR     = 3'd1;
    localparam logic [2:0] ERR_MINUTE   = 3'd2;
    localparam logic [2:0] ERR_MIDNIGHT = 3'd3;
    localparam logic [2:0] ERR_NOON     = 3'd4;
    localparam logic [2:0] ERR_COLON    = 3'd5;
    localparam logic [2:0] ERR_DIGIT    = 3'd6;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [6:0] ACC_MAX   = 7'd127;
    localparam logic [6:0] NOON_HOUR = 7'd12;
    localparam logic [6:0] HOUR_MAX  = 7'd23;
    localparam logic [6:0] MIN_MAX   = 7'd59;

endpackage

### rtl/clock_time_text_parser.sv
// Parses a clock time token such as "9", "7:05P", "12:30" or "12:00M", one upper-case
// character per word with last_char on the final one, and returns one result word per
// token: hour in 24-hour form, minute, an ok flag and an error code (the first error
// found wins; hour and minute read as zero on error). A new character is taken every
// cycle while no final character waits in the input register; a character passes an
// input register and the parse logic, and the result is written to the output register
// as the final character leaves the input register, which waits while an earlier
// result still waits to be taken. Non-final characters keep flowing while a finished
// result waits; only a final character waits for the output register to free.
`include "assert_macros.svh"

module clock_time_text_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ctp_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ctp_pkg::t_out_word   o_out_word
);
    import ctp_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    t_phase     r_phase, n_phase;
    logic [6:0] r_hour, n_hour;
    logic [6:0] r_min, n_min;
    logic [2:0] r_err, n_err;
    logic       r_skip, n_skip;

    logic        proc_fire;
    logic [7:0]  ch;
    logic        is_dig;
    logic [3:0]  dig;
    logic [10:0] hour_mac;
    logic [10:0] min_mac;
    logic [6:0]  hour_sat;
    logic [6:0]  min_sat;
    logic [2:0]  res_code;
    t_out_word   res_word;

    // a non-final character never needs the output register
    assign proc_fire   = r_in_valid &&
                         (!r_in_word.last_char || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign ch       = r_in_word.char_code;
    assign is_dig   = (ch >= CH_0) && (ch <= CH_9);
    assign dig      = 4'(ch - CH_0);
    assign hour_mac = {4'b0, r_hour} * 11'd10 + {7'b0, dig};
    assign min_mac  = {4'b0, r_min} * 11'd10 + {7'b0, dig};
    assign hour_sat = (hour_mac > {4'b0, ACC_MAX}) ? ACC_MAX : hour_mac[6:0];
    assign min_sat  = (min_mac > {4'b0, ACC_MAX}) ? ACC_MAX : min_mac[6:0];

    always_comb begin
        n_phase = r_phase;
        n_hour  = r_hour;
        n_min   = r_min;
        n_err   = r_err;
        n_skip  = r_skip;
        unique case (r_phase)
            PH_HOUR1: begin
                if (!is_dig) begin
                    n_err   = ERR_DIGIT;
                    n_phase = PH_IGNORE;
                end else begin
                    n_hour  = {3'b0, dig};
                    n_phase = PH_HOUR2;
                end
            end
            PH_HOUR2: begin
                priority if (ch == CH_P) begin
                    n_hour  = r_hour + NOON_HOUR;
                    n_phase = PH_MINUTE;
                end else if (ch == CH_A || ch == CH_COLON) begin
                    n_phase = PH_MINUTE;
                end else if (!is_dig) begin
                    n_err   = ERR_DIGIT;
                    n_phase = PH_IGNORE;
                end else begin
                    n_hour  = hour_sat;
                    n_phase = PH_AFTER2;
                end
            end
            PH_AFTER2: begin
                priority if (ch == CH_M) begin
                    n_err   = ERR_MIDNIGHT;
                    n_phase = PH_IGNORE;
                end else if (ch == CH_N) begin
                    n_err   = ERR_NOON;
                    n_phase = PH_IGNORE;
                end else if (ch == CH_P) begin
                    if (r_hour < NOON_HOUR) n_hour = r_hour + NOON_HOUR;
                    n_phase = PH_MINUTE;
                end else if (ch == CH_A) begin
                    if (r_hour == NOON_HOUR) n_hour = '0;
                    n_phase = PH_MINUTE;
                end else if (ch == CH_COLON) begin
                    n_phase = PH_MINUTE;
                end else begin
                    n_err   = ERR_COLON;
                    n_phase = PH_IGNORE;
                end
            end
            PH_MINUTE: begin
                priority if (ch == CH_P) begin
                    if (r_hour < NOON_HOUR) n_hour = r_hour + NOON_HOUR;
                    n_phase = PH_IGNORE;
                end else if (ch == CH_A) begin
                    if (r_hour == NOON_HOUR) n_hour = '0;
                    n_phase = PH_IGNORE;
                end else if (ch == CH_M || ch == CH_N) begin
                    // only hour 12 with minute zero may carry midnight or noon
                    if (r_hour == NOON_HOUR && r_min == '0) begin
                        if (ch == CH_M) n_hour = '0;
                        n_skip = 1'b1;
                    end else begin
                        n_err = (ch == CH_M) ? ERR_MIDNIGHT : ERR_NOON;
                    end
                    n_phase = PH_IGNORE;
                end else if (!is_dig) begin
                    n_err   = ERR_DIGIT;
                    n_phase = PH_IGNORE;
                end else begin
                    n_min = min_sat;
                end
            end
            PH_IGNORE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_code = n_err;
        if (n_err == ERR_NONE && !n_skip) begin
            priority if (n_hour > HOUR_MAX) res_code = ERR_HOUR;
            else if (n_min > MIN_MAX) res_code = ERR_MINUTE;
            else res_code = ERR_NONE;
        end
        res_word.error_code   = res_code;
        res_word.time_ok      = (res_code == ERR_NONE);
        res_word.hour_value   = (res_code == ERR_NONE) ? n_hour[4:0] : '0;
        res_word.minute_value = (res_code == ERR_NONE) ? n_min[5:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HOUR1;
            r_hour      <= '0;
            r_min       <= '0;
            r_err       <= ERR_NONE;
            r_skip      <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire && r_in_word.last_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (proc_fire) begin
                if (r_in_word.last_char) begin
                    r_phase <= PH_HOUR1;
                    r_hour  <= '0;
                    r_min   <= '0;
                    r_err   <= ERR_NONE;
                    r_skip  <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_hour  <= n_hour;
                    r_min   <= n_min;
                    r_err   <= n_err;
                    r_skip  <= n_skip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_word <= i_in_word;
        if (proc_fire && r_in_word.last_char) r_out_word <= res_word;
    end

    `ASSERT_IMPL(a_ok_in_range, r_out_valid && r_out_word.time_ok,
        r_out_word.error_code == ERR_NONE && r_out_word.hour_value <= 5'd23 &&
        r_out_word.minute_value <= 6'd59)
    `ASSERT_IMPL(a_err_zeroes, r_out_valid && !r_out_word.time_ok,
        r_out_word.error_code != ERR_NONE && r_out_word.hour_value == '0 &&
        r_out_word.minute_value == '0)
    `ASSERT_IMPL(a_result_from_last, $rose(r_out_valid),
        $past(proc_fire && r_in_word.last_char))
    `ASSERT_NEXT(a_clear_after_last, proc_fire && r_in_word.last_char,
        r_phase == PH_HOUR1 && r_err == ERR_NONE && !r_skip)
    `ASSERT_IMPL(a_skip_no_err, r_skip, r_err == ERR_NONE && r_phase == PH_IGNORE)

endmodule
